// ===== rtl/i2cms_pkg.sv =====
// Shared types and codes for the I2C master/slave sequencer.
package i2cms_pkg;

   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_ADDR    = 3'd2;
   localparam logic [2:0] ACT_DATA    = 3'd3;
   localparam logic [2:0] ACT_ACK     = 3'd4;
   localparam logic [2:0] ACT_NACK    = 3'd5;
   localparam logic [2:0] ACT_STOP    = 3'd6;
   localparam logic [2:0] ACT_RELEASE = 3'd7;

   localparam logic [1:0] MODE_READY = 2'd0;
   localparam logic [1:0] MODE_MTX   = 2'd1;
   localparam logic [1:0] MODE_MRX   = 2'd2;
   localparam logic [1:0] MODE_SRX   = 2'd3;

   localparam logic [1:0] KIND_LOAD     = 2'd0;
   localparam logic [1:0] KIND_START_WR = 2'd1;
   localparam logic [1:0] KIND_START_RD = 2'd2;
   localparam logic [1:0] KIND_EVENT    = 2'd3;

   localparam logic RW_READ  = 1'b1;
   localparam logic RW_WRITE = 1'b0;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] target_address;
      logic [7:0] data_byte;
      logic [3:0] amount;
      logic       last_byte;
      logic [4:0] bus_event;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] out_byte;
      logic [7:0] rx_byte;
      logic [3:0] rx_count;
      logic       delivered;
      logic       run_last;
      logic       request_reply;
      logic       rejected;
      logic [1:0] bus_mode;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_LOAD,
      OP_START_WR,
      OP_START_RD,
      OP_EV_START,
      OP_MT_ACK,
      OP_BUS_STOP,
      OP_MR_ADDR_ACK,
      OP_MR_DATA,
      OP_SR_ADDR,
      OP_SR_DATA,
      OP_LOST,
      OP_SR_NACK,
      OP_ST_ADDR,
      OP_ST_DATA,
      OP_ST_END,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] address;
      logic [7:0] data;
      logic [3:0] amount;
      logic       last_byte;
   } entry_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_EXEC,
      B_DREAD,
      B_DLOAD,
      B_HOLD
   } back_state_type;

endpackage

// ===== rtl/i2c_master_slave_sequencer.sv =====
// Top level of the I2C master/slave sequencer: front end, queue and back end.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_data  (req_type)
//  rsp      out        rsp_valid/rsp_ready    rsp_data  (rsp_type)
//
// A transfer accepted into an empty queue is at the queue head in the next
// cycle; the back end checks the head while idle, then executes it and loads
// the result register or starts a delivery run, so every operation passes
// through check, execute and hold.
// A delivery run passes each received byte through receive store read,
// result register load and hold; a result stalls until rsp_ready.
// The two-entry queue keeps taking requests while a result waits, until full.
// Reset is synchronous; no clearing pass is needed.
module i2c_master_slave_sequencer
   import i2cms_pkg::*;
#(
   parameter int BUFFER_DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_valid;
   entry_type q_wdata;
   entry_type q_rdata;

   i2cms_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   i2cms_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .rdata (q_rdata)
   );

   i2cms_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/i2cms_front.sv =====
// Front end: accepts request transfers and classifies them into operations.
module i2cms_front
   import i2cms_pkg::*;
(
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_wdata
);

   op_type op;

   always_comb begin
      op = OP_NONE;
      case (req_data.kind)
         KIND_LOAD:     op = OP_LOAD;
         KIND_START_WR: op = OP_START_WR;
         KIND_START_RD: op = OP_START_RD;
         default: begin
            case (req_data.bus_event) inside
               [5'd0:5'd1]:           op = OP_EV_START;
               [5'd2:5'd3]:           op = OP_MT_ACK;
               5'd4, 5'd5, 5'd8, 5'd9: op = OP_BUS_STOP;
               5'd6:                  op = OP_MR_ADDR_ACK;
               5'd7:                  op = OP_MR_DATA;
               [5'd10:5'd13]:         op = OP_SR_ADDR;
               [5'd14:5'd15]:         op = OP_SR_DATA;
               [5'd16:5'd17]:         op = OP_LOST;
               [5'd18:5'd19]:         op = OP_SR_NACK;
               5'd20:                 op = OP_ST_ADDR;
               5'd21:                 op = OP_ST_DATA;
               [5'd22:5'd23]:         op = OP_ST_END;
               default:               op = OP_NONE;
            endcase
         end
      endcase
   end

   assign req_ready         = !q_full;
   assign q_push            = req_valid && !q_full;
   assign q_wdata.op        = op;
   assign q_wdata.address   = req_data.target_address;
   assign q_wdata.data      = req_data.data_byte;
   assign q_wdata.amount    = req_data.amount;
   assign q_wdata.last_byte = req_data.last_byte;

endmodule

// ===== rtl/i2cms_queue.sv =====
// Two-entry operation queue between front end and sequencer.
module i2cms_queue
   import i2cms_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wdata,
   output logic      full,
   input  logic      pop,
   output logic      valid,
   output entry_type rdata
);

   localparam int DEPTH = 2;

   entry_type  slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign full  = (count_ff == 2'(DEPTH));
   assign valid = (count_ff != 2'd0);
   assign rdata = slot_ff[rd_ptr_ff];

endmodule

// ===== rtl/i2cms_back.sv =====
// Back end: bus sequencer state, transmit/receive stores and result register.
module i2cms_back
   import i2cms_pkg::*;
#(
   parameter int BUFFER_DEPTH = 8
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  entry_type q_entry,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int MW = ((CW > 4) ? CW : 4) + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

   back_state_type state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] tx_pos_ff, tx_pos_in;
   logic [CW-1:0] tx_end_ff, tx_end_in;
   logic [CW-1:0] load_pos_ff, load_pos_in;
   logic [CW-1:0] rx_pos_ff, rx_pos_in;
   logic [6:0]    peer_ff, peer_in;
   logic [3:0]    wanted_ff, wanted_in;
   logic [CW-1:0] del_i_ff, del_i_in;
   logic [CW-1:0] del_n_ff, del_n_in;
   logic [2:0]    del_act_ff, del_act_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [7:0]    tx_mem [BUFFER_DEPTH];
   logic [7:0]    rx_mem [BUFFER_DEPTH];
   logic [7:0]    tx_rd_ff;
   logic [7:0]    rx_rd_ff;
   logic          tx_we;
   logic          rx_we;
   logic [IW-1:0] tx_raddr;
   logic [IW-1:0] rx_raddr;

   assign tx_raddr = (q_entry.op == OP_ST_ADDR) ? '0 : tx_pos_ff[IW-1:0];
   assign rx_raddr = del_i_ff[IW-1:0];

   always_comb begin
      rsp_type       res;
      logic          deliver;
      logic          tx_more;
      logic [CW-1:0] dn;
      logic [CW-1:0] lp_next;
      logic [CW:0]   rx_next;
      logic          last;

      state_in     = state_ff;
      mode_in      = mode_ff;
      tx_pos_in    = tx_pos_ff;
      tx_end_in    = tx_end_ff;
      load_pos_in  = load_pos_ff;
      rx_pos_in    = rx_pos_ff;
      peer_in      = peer_ff;
      wanted_in    = wanted_ff;
      del_i_in     = del_i_ff;
      del_n_in     = del_n_ff;
      del_act_in   = del_act_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      tx_we        = 1'b0;
      rx_we        = 1'b0;
      res          = '0;
      deliver      = 1'b0;
      dn           = rx_pos_ff;
      lp_next      = load_pos_ff + 1'b1;
      rx_next      = {1'b0, rx_pos_ff} + 1'b1;
      tx_more      = (tx_pos_ff < tx_end_ff) && (tx_pos_ff < DEPTH_C);
      last         = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            q_pop        = 1'b1;
            res.run_last = 1'b1;
            case (q_entry.op)
               OP_LOAD: begin
                  if (load_pos_ff < DEPTH_C) begin
                     tx_we       = 1'b1;
                     load_pos_in = lp_next;
                  end else begin
                     res.rejected = 1'b1;
                  end
                  if (q_entry.last_byte) begin
                     tx_end_in   = (load_pos_ff < DEPTH_C) ? lp_next : load_pos_ff;
                     tx_pos_in   = '0;
                     load_pos_in = '0;
                  end
               end
               OP_START_WR, OP_START_RD: begin
                  if (mode_ff != MODE_READY) begin
                     res.rejected = 1'b1;
                  end else begin
                     peer_in    = q_entry.address;
                     res.action = ACT_START;
                     if (q_entry.op == OP_START_WR) begin
                        tx_pos_in = '0;
                        mode_in   = MODE_MTX;
                     end else begin
                        wanted_in = q_entry.amount;
                        mode_in   = MODE_MRX;
                     end
                  end
               end
               OP_EV_START: begin
                  if (mode_ff == MODE_MTX) begin
                     res.action   = ACT_ADDR;
                     res.out_byte = {peer_ff, RW_WRITE};
                  end else if (mode_ff == MODE_MRX) begin
                     res.action   = ACT_ADDR;
                     res.out_byte = {peer_ff, RW_READ};
                  end
               end
               OP_MT_ACK: begin
                  if (tx_more) begin
                     res.action   = ACT_DATA;
                     res.out_byte = tx_rd_ff;
                     tx_pos_in    = tx_pos_ff + 1'b1;
                  end else begin
                     mode_in    = MODE_READY;
                     res.action = ACT_STOP;
                  end
               end
               OP_BUS_STOP: begin
                  mode_in    = MODE_READY;
                  res.action = ACT_STOP;
               end
               OP_MR_ADDR_ACK: begin
                  rx_pos_in  = '0;
                  res.action = ACT_ACK;
               end
               OP_MR_DATA: begin
                  if (rx_pos_ff >= DEPTH_C) begin
                     mode_in    = MODE_READY;
                     res.action = ACT_STOP;
                  end else begin
                     rx_we     = 1'b1;
                     rx_pos_in = rx_next[CW-1:0];
                     if ((MW'(rx_next) >= MW'(wanted_ff)) ||
                         (rx_next >= (CW+1)'(BUFFER_DEPTH))) begin
                        mode_in    = MODE_READY;
                        res.action = ACT_STOP;
                        deliver    = 1'b1;
                        dn         = rx_next[CW-1:0];
                     end else begin
                        res.action = ACT_ACK;
                     end
                  end
               end
               OP_SR_ADDR: begin
                  mode_in    = MODE_SRX;
                  rx_pos_in  = '0;
                  res.action = ACT_ACK;
               end
               OP_SR_DATA: begin
                  if (rx_pos_ff >= DEPTH_C) begin
                     res.action = ACT_NACK;
                  end else begin
                     rx_we      = 1'b1;
                     rx_pos_in  = rx_next[CW-1:0];
                     res.action = ACT_ACK;
                  end
               end
               OP_LOST: begin
                  mode_in    = MODE_READY;
                  res.action = ACT_RELEASE;
                  deliver    = 1'b1;
               end
               OP_SR_NACK: begin
                  res.action = ACT_NACK;
               end
               OP_ST_ADDR: begin
                  res.request_reply = 1'b1;
                  tx_pos_in         = '0;
                  if ((tx_end_ff != '0) && (DEPTH_C != '0)) begin
                     res.action   = ACT_DATA;
                     res.out_byte = tx_rd_ff;
                     tx_pos_in    = CW'(1);
                  end
               end
               OP_ST_DATA: begin
                  if (tx_more) begin
                     res.action   = ACT_DATA;
                     res.out_byte = tx_rd_ff;
                     tx_pos_in    = tx_pos_ff + 1'b1;
                  end
               end
               OP_ST_END: begin
                  mode_in    = MODE_READY;
                  res.action = ACT_RELEASE;
               end
               default: begin
                  res.action = ACT_NONE;
               end
            endcase
            res.bus_mode = mode_in;
            if (deliver && (dn != '0)) begin
               del_n_in   = dn;
               del_i_in   = '0;
               del_act_in = res.action;
               state_in   = B_DREAD;
            end else begin
               res.delivered = deliver;
               rsp_data_in   = res;
               rsp_valid_in  = 1'b1;
               state_in      = B_HOLD;
            end
         end
         B_DREAD: begin
            state_in = B_DLOAD;
         end
         B_DLOAD: begin
            last          = ({1'b0, del_i_ff} + 1'b1) == {1'b0, del_n_ff};
            res.rx_byte   = rx_rd_ff;
            res.rx_count  = 4'(del_n_ff);
            res.delivered = 1'b1;
            res.run_last  = last;
            res.action    = last ? del_act_ff : ACT_NONE;
            res.bus_mode  = mode_ff;
            rsp_data_in   = res;
            rsp_valid_in  = 1'b1;
            state_in      = B_HOLD;
         end
         B_HOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_data_ff.delivered && !rsp_data_ff.run_last) begin
                  del_i_in = del_i_ff + 1'b1;
                  state_in = B_DREAD;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         mode_ff      <= MODE_READY;
         tx_pos_ff    <= '0;
         tx_end_ff    <= '0;
         load_pos_ff  <= '0;
         rx_pos_ff    <= '0;
         peer_ff      <= '0;
         wanted_ff    <= '0;
         del_i_ff     <= '0;
         del_n_ff     <= '0;
         del_act_ff   <= ACT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         tx_pos_ff    <= tx_pos_in;
         tx_end_ff    <= tx_end_in;
         load_pos_ff  <= load_pos_in;
         rx_pos_ff    <= rx_pos_in;
         peer_ff      <= peer_in;
         wanted_ff    <= wanted_in;
         del_i_ff     <= del_i_in;
         del_n_ff     <= del_n_in;
         del_act_ff   <= del_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[load_pos_ff[IW-1:0]] <= q_entry.data;
      end
      tx_rd_ff <= tx_mem[tx_raddr];
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_pos_ff[IW-1:0]] <= q_entry.data;
      end
      rx_rd_ff <= rx_mem[rx_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
